>>> sv/mtf_pkg.sv
// Package for the move-to-front list: sizes, beat structs and the match summary.
// Depends on nothing; used by every module of the block.
`default_nettype none
package mtf_pkg;

    // number of entries the list holds (2 to 31)
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int VAL_W    = 32;

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_FIND   = 1'b1;

    // input beat
    typedef struct packed {
        logic                    command;
        logic signed [VAL_W-1:0] value;
    } mtf_req_t;

    // result beat
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             rejected;
    } mtf_rsp_t;

    // outcome of one search across the cells
    typedef struct packed {
        logic                hit;
        logic [IDX_W-1:0]    index;
        logic [CAPACITY-1:0] mask;
    } mtf_match_t;

endpackage
`default_nettype wire

>>> sv/move_to_front_list.sv
// Top level of the move-to-front list: control, result register and the row
// of cells. Depends on mtf_pkg, mtf_cell and mtf_find.
`default_nettype none
// Usage:
//   Input channel: drive req (command and value) with start high; the beat is
//   taken at a rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle with rsp valid; the
//   receiver cannot stall, so the beat is taken at the end of that cycle.
//   Latency: the cycle after the input beat every cell compares its entry
//   with the key; in the following cycle done is high with the result and
//   the selected cells shift at the end of it.
//   Back-to-back beats: each beat passes the compare cycle and then the shift
//   cycle of the cell row; busy is high only in the compare cycle, so a new
//   beat may be taken in the same cycle that a result shows.
//   Insert: value enters cell 0 and all others move back one; into a full
//   list it is refused and rejected is set.
//   Find: the first matching cell and all in front of it shift, the key
//   lands in cell 0; found and the one-based position before the move are
//   reported.
//   Reset: the list is empty (all valid flags and the entry count cleared);
//   no clearing pass is needed and a beat may be taken right after reset.
module move_to_front_list (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire mtf_pkg::mtf_req_t req,
    output logic                   done,
    output mtf_pkg::mtf_rsp_t      rsp
);
    import mtf_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CMP   = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CAPACITY-1:0] mask_reg, mask_next;
    mtf_rsp_t            rsp_reg, rsp_next;
    logic signed [VAL_W-1:0] key_reg;
    logic                cmd_reg;

    logic signed [VAL_W-1:0] cell_data [CAPACITY];
    logic [CAPACITY-1:0]     cell_valid;
    logic [CAPACITY-1:0]     hits;
    logic [CAPACITY-1:0]     shift_en;
    mtf_match_t              match;
    logic                    accept;
    logic                    full;

    assign accept   = start && !busy;
    assign busy     = (state_reg == ST_CMP);
    assign done     = (state_reg == ST_SHIFT);
    assign rsp      = rsp_reg;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign shift_en = done ? mask_reg : '0;

    // row of cells; cell 0 takes the key
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        if (g == 0)
        begin : g_front
            mtf_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .key        (key_reg),
                .shift_en   (shift_en[g]),
                .prev_data  (key_reg),
                .prev_valid (1'b1),
                .data       (cell_data[g]),
                .valid      (cell_valid[g]),
                .hit        (hits[g])
            );
        end
        else
        begin : g_rest
            mtf_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .key        (key_reg),
                .shift_en   (shift_en[g]),
                .prev_data  (cell_data[g-1]),
                .prev_valid (cell_valid[g-1]),
                .data       (cell_data[g]),
                .valid      (cell_valid[g]),
                .hit        (hits[g])
            );
        end
    end

    mtf_find u_find (
        .hits  (hits),
        .match (match)
    );

    // sequencing, shift mask and result
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        mask_next  = mask_reg;
        rsp_next   = rsp_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_SHIFT;
                rsp_next   = '0;
                if (cmd_reg == CMD_INSERT)
                begin
                    if (full)
                    begin
                        mask_next        = '0;
                        rsp_next.rejected = 1'b1;
                    end
                    else
                    begin
                        mask_next  = '1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    mask_next         = match.mask;
                    rsp_next.found    = match.hit;
                    rsp_next.position = match.hit
                        ? POS_W'({1'b0, match.index} + (IDX_W + 1)'(1)) : '0;
                end
            end
            ST_SHIFT:
            begin
                state_next = accept ? ST_CMP : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            mask_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            mask_reg  <= mask_next;
        end
    end

    // beat payload and result
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (accept)
        begin
            key_reg <= req.value;
            cmd_reg <= req.command;
        end
    end

endmodule
`default_nettype wire

>>> sv/mtf_cell.sv
// One list cell: holds an entry and its valid flag, compares against the key
// and takes its front neighbour's entry when told to shift. Depends on mtf_pkg.
`default_nettype none
module mtf_cell (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic signed [mtf_pkg::VAL_W-1:0] key,
    input  wire logic                            shift_en,
    input  wire logic signed [mtf_pkg::VAL_W-1:0] prev_data,
    input  wire logic                            prev_valid,
    output logic signed [mtf_pkg::VAL_W-1:0]      data,
    output logic                                 valid,
    output logic                                 hit
);
    import mtf_pkg::*;

    logic signed [VAL_W-1:0] data_reg;
    logic                    valid_reg;

    // valid flag, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            valid_reg <= prev_valid;
        end
    end

    // entry payload, no reset
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            data_reg <= prev_data;
        end
    end

    assign data  = data_reg;
    assign valid = valid_reg;
    assign hit   = valid_reg && (data_reg == key);

endmodule
`default_nettype wire

>>> sv/mtf_find.sv
// First-hit search over the cells' compare flags: gives the index nearest the
// front and the mask of cells that shift to bring it there. Depends on mtf_pkg.
`default_nettype none
module mtf_find (
    input  wire logic [mtf_pkg::CAPACITY-1:0] hits,
    output mtf_pkg::mtf_match_t               match
);
    import mtf_pkg::*;

    // scan from the front; cells up to and including the first hit shift, none without a hit
    always_comb
    begin
        logic seen;
        seen        = 1'b0;
        match.index = '0;
        match.mask  = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            match.mask[k] = !seen;
            if (hits[k] && !seen)
            begin
                match.index = IDX_W'(k);
            end
            seen = seen | hits[k];
        end
        match.hit = seen;
        if (!seen)
        begin
            match.mask = '0;
        end
    end

endmodule
`default_nettype wire
